// File: rtl/core/cpat_pkg.sv
// Shared types and constants of the color pair allocation table.
`timescale 1ns / 1ps

package cpat_pkg;

  // Fixed field widths of the request and response beats.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned COLOR_W   = 26;
  localparam int unsigned ATTR_IN_W = 16;
  localparam int unsigned PAIR_W    = 6;

  // Request operation codes. The fourth code is unused and ignored.
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC    = 2'd0,
    OP_FREE_TMP = 2'd1,
    OP_FREE_ALL = 2'd2
  } op_e;

  // States of the sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } seq_state_e;

  // One request beat as seen by the sequencer.
  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [COLOR_W-1:0] fg_index;
    logic signed [COLOR_W-1:0] bg_index;
    logic [ATTR_IN_W-1:0]    attr_bits;
    logic                    temporary;
  } req_t;

  // One response beat.
  typedef struct packed {
    logic [PAIR_W-1:0] pair_idx;
    logic              hit;
    logic              table_full;
  } res_t;

endpackage

// File: rtl/core/cpat_if.sv
// Request and response channel interfaces of the color pair allocation table.
`timescale 1ns / 1ps

interface cpat_req_if
  import cpat_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [COLOR_W-1:0] fg_index;
  logic signed [COLOR_W-1:0] bg_index;
  logic [ATTR_IN_W-1:0]      attr_bits;
  logic                      temporary;

  modport source (
    output valid, operation, fg_index, bg_index, attr_bits, temporary,
    input  ready
  );

  modport sink (
    input  valid, operation, fg_index, bg_index, attr_bits, temporary,
    output ready
  );
endinterface

interface cpat_rsp_if
  import cpat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [PAIR_W-1:0] pair_idx;
  logic              hit;
  logic              table_full;

  modport source (
    output valid, pair_idx, hit, table_full,
    input  ready
  );

  modport sink (
    input  valid, pair_idx, hit, table_full,
    output ready
  );
endinterface

// File: rtl/core/cpat_key_mem.sv
// Key storage: one write port and one registered read port.
`timescale 1ns / 1ps

module cpat_key_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned KEY_W = 68,
  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IdxW-1:0]  wr_addr_i,
  input  logic [KEY_W-1:0] wr_key_i,
  input  logic             rd_en_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  output logic [KEY_W-1:0] rd_key_o
);

  logic [KEY_W-1:0] mem_q [DEPTH];
  logic [KEY_W-1:0] rd_key_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_key_o = rd_key_q;

endmodule

// File: rtl/core/cpat_seq.sv
// Sequencer: scans the table through one shared key comparator, allocates and frees entries.
`timescale 1ns / 1ps

module cpat_seq
  import cpat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ATTR_WIDTH  = 16,
  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned AttrW = (ATTR_WIDTH < ATTR_IN_W) ? ATTR_WIDTH : ATTR_IN_W,
  localparam int unsigned KeyW  = 2 * COLOR_W + AttrW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  req_t            req_i,
  output logic            res_valid_o,
  input  logic            res_take_i,
  output res_t            res_o,
  output logic            rd_en_o,
  output logic [IdxW-1:0] rd_addr_o,
  input  logic [KeyW-1:0] rd_key_i,
  output logic            wr_en_o,
  output logic [IdxW-1:0] wr_addr_o,
  output logic [KeyW-1:0] wr_key_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);

  seq_state_e             state_q, state_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [TABLE_DEPTH-1:0] tmp_q, tmp_d;
  logic [IdxW-1:0]        scan_cnt_q, scan_cnt_d;
  logic                   iss_done_q, iss_done_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]        cmp_idx_q, cmp_idx_d;
  logic                   free_fnd_q, free_fnd_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic [KeyW-1:0]        key_q, key_d;
  logic                   temp_q, temp_d;
  res_t                   res_q, res_d;

  logic            accept;
  logic            match;
  logic            cur_free;
  logic            scan_last;
  logic            alloc_ok;
  logic [IdxW-1:0] alloc_idx;

  // The shared compare unit looks at the entry whose key arrived this cycle.
  always_comb begin
    match     = cmp_vld_q && valid_q[cmp_idx_q] && (rd_key_i == key_q);
    cur_free  = cmp_vld_q && !valid_q[cmp_idx_q];
    scan_last = cmp_vld_q && (cmp_idx_q == LastIdx);
    alloc_ok  = free_fnd_q || cur_free;
    alloc_idx = free_fnd_q ? free_idx_q : cmp_idx_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_e'(req_i.operation) == OP_ALLOC) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (match || scan_last) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_RESULT);
    rd_en_o     = (state_q == ST_SCAN) && !iss_done_q;
    rd_addr_o   = scan_cnt_q;
    res_o       = res_q;
  end

  assign accept = in_valid_i && in_ready_o;

  // Datapath and table bookkeeping.
  always_comb begin
    valid_d    = valid_q;
    tmp_d      = tmp_q;
    scan_cnt_d = scan_cnt_q;
    iss_done_d = iss_done_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;
    key_d      = key_q;
    temp_d     = temp_q;
    res_d      = res_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = alloc_idx;
    wr_key_o   = key_q;

    if (accept) begin
      key_d      = {req_i.fg_index, req_i.bg_index, req_i.attr_bits[AttrW-1:0]};
      temp_d     = req_i.temporary;
      scan_cnt_d = '0;
      iss_done_d = 1'b0;
      free_fnd_d = 1'b0;
      res_d      = '0;
      unique case (op_e'(req_i.operation))
        OP_FREE_TMP: begin
          valid_d = valid_q & ~tmp_q;
          tmp_d   = '0;
        end
        OP_FREE_ALL: begin
          valid_d = '0;
          tmp_d   = '0;
        end
        default: ;
      endcase
    end

    if (state_q == ST_SCAN) begin
      if (rd_en_o) begin
        cmp_vld_d = 1'b1;
        cmp_idx_d = scan_cnt_q;
        if (scan_cnt_q == LastIdx) begin
          iss_done_d = 1'b1;
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      if (cur_free && !free_fnd_q) begin
        free_fnd_d = 1'b1;
        free_idx_d = cmp_idx_q;
      end
      if (match) begin
        res_d.pair_idx   = PAIR_W'(cmp_idx_q);
        res_d.hit        = 1'b1;
        res_d.table_full = 1'b0;
      end else if (scan_last) begin
        if (alloc_ok) begin
          wr_en_o            = 1'b1;
          valid_d[alloc_idx] = 1'b1;
          tmp_d[alloc_idx]   = temp_q;
          res_d.pair_idx     = PAIR_W'(alloc_idx);
          res_d.hit          = 1'b0;
          res_d.table_full   = 1'b0;
        end else begin
          res_d.pair_idx   = '0;
          res_d.hit        = 1'b0;
          res_d.table_full = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      tmp_q      <= '0;
      scan_cnt_q <= '0;
      iss_done_q <= 1'b0;
      cmp_vld_q  <= 1'b0;
      free_fnd_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      tmp_q      <= tmp_d;
      scan_cnt_q <= scan_cnt_d;
      iss_done_q <= iss_done_d;
      cmp_vld_q  <= cmp_vld_d;
      free_fnd_q <= free_fnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    key_q      <= key_d;
    temp_q     <= temp_d;
    res_q      <= res_d;
  end

  // A temporary mark only ever sits on a valid entry.
  a_tmp_subset_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tmp_q & ~valid_q) == '0)
    else $error("temporary mark on an invalid entry");

  // A new key always lands in a slot that is valid afterwards.
  a_alloc_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> valid_q[$past(wr_addr_o)])
    else $error("allocated slot not marked valid");

  // The full flag is only raised when every slot is taken.
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_last && !match && !alloc_ok) |-> (&valid_q))
    else $error("table reported full with a free slot");

  // A result never claims both a hit and a failed allocation.
  a_hit_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(res_o.hit && res_o.table_full))
    else $error("result has both hit and full set");

endmodule

// File: rtl/core/color_pair_alloc_table.sv
// Top level of the color pair allocation table.
`timescale 1ns / 1ps

//  Channel | Modport      | Beat carries
//  --------+--------------+-----------------------------------------------------
//  req_i   | sink         | operation, fg_index, bg_index, attr_bits, temporary
//  rsp_o   | source       | pair_idx, hit, table_full
//
// An allocate request scans all TABLE_DEPTH entries before its response, or
// stops early when a matching entry is found in the scan. The scan reads one
// stored key per cycle from the key memory, whose read is registered, and
// feeds it to the single key comparator; that one read port sets the rate.
// Free requests and the unused operation code skip the scan. Reset empties
// the table at once, since the valid and temporary marks live in flip-flops;
// the stored keys need no clearing. A stalled response beat is held in the
// output register while the next request is already accepted and worked on.

module color_pair_alloc_table
  import cpat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned ATTR_WIDTH  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cpat_req_if.sink   req_i,
  cpat_rsp_if.source rsp_o
);

  localparam int unsigned IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned AttrW = (ATTR_WIDTH < ATTR_IN_W) ? ATTR_WIDTH : ATTR_IN_W;
  localparam int unsigned KeyW  = 2 * COLOR_W + AttrW;

  req_t            req;
  res_t            res;
  logic            in_ready;
  logic            res_valid;
  logic            res_take;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic [KeyW-1:0] rd_key;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [KeyW-1:0] wr_key;

  // Output register that parts the response channel from the sequencer.
  logic rsp_vld_q, rsp_vld_d;
  res_t rsp_q;

  // Gather the request beat into one struct for the sequencer.
  assign req.operation = req_i.operation;
  assign req.fg_index  = req_i.fg_index;
  assign req.bg_index  = req_i.bg_index;
  assign req.attr_bits = req_i.attr_bits;
  assign req.temporary = req_i.temporary;
  assign req_i.ready   = in_ready;

  cpat_key_mem #(
    .DEPTH (TABLE_DEPTH),
    .KEY_W (KeyW)
  ) u_key_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key)
  );

  cpat_seq #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ATTR_WIDTH  (ATTR_WIDTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_key_i    (rd_key),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_key_o    (wr_key)
  );

  // A finished result moves into the output register whenever it is empty or
  // its current beat is being taken in the same cycle.
  assign res_take = res_valid && (!rsp_vld_q || rsp_o.ready);

  always_comb begin
    if (res_take) begin
      rsp_vld_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end else begin
      rsp_vld_d = rsp_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else begin
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.pair_idx   = rsp_q.pair_idx;
  assign rsp_o.hit        = rsp_q.hit;
  assign rsp_o.table_full = rsp_q.table_full;

endmodule
